FILE: rtl/ucq_pkg.sv
package ucq_pkg;

    localparam int STEP_COUNT = 14;
    localparam int NUM_CELLS  = STEP_COUNT + 1;
    localparam int DATA_W     = 16;
    localparam int SHIFT_W    = 4;
    localparam int STAGE_W    = 4;
    localparam int ADDR_W     = 3;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] MODE_CIRC = 2'd0;
    localparam logic [1:0] MODE_LIN  = 2'd1;
    localparam logic [1:0] MODE_HYP  = 2'd2;

    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    localparam logic signed [DATA_W-1:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic signed [DATA_W-1:0] z_in;
    } operand_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic signed [DATA_W-1:0] z_out;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic       vectoring;
        logic [1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic                     active;
        logic                     vectoring;
        logic                     linear;
        logic                     hyper;
        logic [SHIFT_W-1:0]       shift;
        logic signed [DATA_W-1:0] angle;
    } cell_ctrl_t;

    function automatic logic signed [DATA_W-1:0] circ_angle(logic [STAGE_W-1:0] stage);
        logic signed [DATA_W-1:0] a;
        unique case (stage)
            4'd0:    a = 16'sd12867;
            4'd1:    a = 16'sd7596;
            4'd2:    a = 16'sd4013;
            4'd3:    a = 16'sd2037;
            4'd4:    a = 16'sd1022;
            4'd5:    a = 16'sd511;
            4'd6:    a = 16'sd255;
            4'd7:    a = 16'sd127;
            4'd8:    a = 16'sd63;
            4'd9:    a = 16'sd31;
            4'd10:   a = 16'sd15;
            4'd11:   a = 16'sd7;
            4'd12:   a = 16'sd3;
            4'd13:   a = 16'sd1;
            default: a = 16'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [DATA_W-1:0] hyp_angle(logic [SHIFT_W-1:0] shift);
        logic signed [DATA_W-1:0] a;
        unique case (shift)
            4'd1:    a = 16'sd8999;
            4'd2:    a = 16'sd4184;
            4'd3:    a = 16'sd2058;
            4'd4:    a = 16'sd1025;
            4'd5:    a = 16'sd512;
            4'd6:    a = 16'sd256;
            4'd7:    a = 16'sd128;
            4'd8:    a = 16'sd64;
            4'd9:    a = 16'sd32;
            4'd10:   a = 16'sd16;
            4'd11:   a = 16'sd8;
            4'd12:   a = 16'sd4;
            4'd13:   a = 16'sd2;
            default: a = 16'sd0;
        endcase
        return a;
    endfunction

    // Hyperbolic shifts 1..13 with 4 and 13 repeated
    function automatic logic [SHIFT_W-1:0] hyp_shift(logic [STAGE_W-1:0] stage);
        logic [SHIFT_W-1:0] s;
        if (stage < 4'd4)
        begin
            s = stage + 4'd1;
        end
        else if (stage < 4'd14)
        begin
            s = stage;
        end
        else
        begin
            s = 4'd13;
        end
        return s;
    endfunction

    function automatic cell_ctrl_t stage_ctrl(logic [STAGE_W-1:0] stage, cfg_t cfg);
        cell_ctrl_t c;
        c.vectoring = cfg.vectoring;
        c.hyper     = (cfg.mode == MODE_HYP);
        c.linear    = (cfg.mode == MODE_LIN);
        c.active    = c.hyper || (stage < STEP_COUNT[STAGE_W-1:0]);
        if (c.hyper)
        begin
            c.shift = hyp_shift(stage);
            c.angle = hyp_angle(c.shift);
        end
        else if (c.linear)
        begin
            c.shift = stage;
            c.angle = ONE_Q14 >>> stage;
        end
        else
        begin
            c.shift = stage;
            c.angle = circ_angle(stage);
        end
        return c;
    endfunction

endpackage

FILE: rtl/unified_cordic_q2_14.sv
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+------------------------------
// operand   | operand_valid / operand_ready    | operand (x_in, y_in, z_in)
// result    | result_valid / result_ready      | result (x_out, y_out, z_out)
// config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// Each operand passes one registered cell per micro-rotation, in every mode;
// the last cell passes data through unless the mode is hyperbolic.
// One operand per cycle is sustained while result_ready is high.
// rst_n clears all cell valid bits and both registers to zero.
// A stalled result holds only the cells that are full behind it; empty
// cells keep filling, so operands are taken until the chain is full.
module unified_cordic_q2_14
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              operand_valid,
    output logic                              operand_ready,
    input  ucq_pkg::operand_t                 operand,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ucq_pkg::result_t                  result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ucq_pkg::ADDR_W-1:0]        paddr,
    input  logic [ucq_pkg::PDATA_W-1:0]       pwdata,
    output logic [ucq_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    ucq_pkg::cfg_t cfg;
    ucq_pkg::vec_t chain_data  [0:ucq_pkg::NUM_CELLS];
    logic          chain_valid [0:ucq_pkg::NUM_CELLS];
    logic          chain_ready [0:ucq_pkg::NUM_CELLS];

    ucq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign chain_valid[0]  = operand_valid;
    assign chain_data[0].x = operand.x_in;
    assign chain_data[0].y = operand.y_in;
    assign chain_data[0].z = operand.z_in;
    assign operand_ready   = chain_ready[0];

    for (genvar i = 0; i < ucq_pkg::NUM_CELLS; i++)
    begin : g_cell
        ucq_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ucq_pkg::stage_ctrl(ucq_pkg::STAGE_W'(i), cfg)),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    assign chain_ready[ucq_pkg::NUM_CELLS] = result_ready;
    assign result_valid = chain_valid[ucq_pkg::NUM_CELLS];
    assign result.x_out = chain_data[ucq_pkg::NUM_CELLS].x;
    assign result.y_out = chain_data[ucq_pkg::NUM_CELLS].y;
    assign result.z_out = chain_data[ucq_pkg::NUM_CELLS].z;

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !operand_ready |-> result_valid && !result_ready)
        else $error("operand stall without a blocked result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("blocked result changed");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[ucq_pkg::ADDR_W-1] == ucq_pkg::REG_MODE
        |=> cfg.mode == $past(pwdata[1:0]))
        else $error("mode register write lost");

    a_dir_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[ucq_pkg::ADDR_W-1] == ucq_pkg::REG_DIRECTION
        |=> cfg.vectoring == $past(pwdata[0]))
        else $error("direction register write lost");

endmodule

FILE: rtl/ucq_regs.sv
module ucq_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ucq_pkg::ADDR_W-1:0]        paddr,
    input  logic [ucq_pkg::PDATA_W-1:0]       pwdata,
    output logic [ucq_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    output ucq_pkg::cfg_t                     cfg
);

    logic       dir_reg;
    logic       dir_next;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ucq_pkg::ADDR_W-1];

    always_comb
    begin
        dir_next  = dir_reg;
        mode_next = mode_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                ucq_pkg::REG_DIRECTION: dir_next  = pwdata[0];
                ucq_pkg::REG_MODE:      mode_next = pwdata[1:0];
                default:                dir_next  = dir_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            mode_reg <= ucq_pkg::MODE_CIRC;
        end
        else
        begin
            dir_reg  <= dir_next;
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            ucq_pkg::REG_DIRECTION: prdata = {{(ucq_pkg::PDATA_W-1){1'b0}}, dir_reg};
            ucq_pkg::REG_MODE:      prdata = {{(ucq_pkg::PDATA_W-2){1'b0}}, mode_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.vectoring = dir_reg;
    assign cfg.mode      = mode_reg;

endmodule

FILE: rtl/ucq_cell.sv
module ucq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  ucq_pkg::cell_ctrl_t ctrl,
    input  logic                up_valid,
    output logic                up_ready,
    input  ucq_pkg::vec_t       up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output ucq_pkg::vec_t       dn_data
);

    logic                              valid_reg;
    logic                              valid_next;
    ucq_pkg::vec_t                     data_reg;
    ucq_pkg::vec_t                     data_next;
    logic signed [ucq_pkg::DATA_W-1:0] xs;
    logic signed [ucq_pkg::DATA_W-1:0] ys;
    logic                              neg;

    assign up_ready = !valid_reg || dn_ready;
    assign xs       = up_data.x >>> ctrl.shift;
    assign ys       = up_data.y >>> ctrl.shift;
    assign neg      = ctrl.vectoring ? !up_data.y[ucq_pkg::DATA_W-1]
                                     : up_data.z[ucq_pkg::DATA_W-1];

    always_comb
    begin
        data_next = up_data;
        if (ctrl.active)
        begin
            data_next.y = neg ? up_data.y - xs : up_data.y + xs;
            data_next.z = neg ? up_data.z + ctrl.angle : up_data.z - ctrl.angle;
            priority if (ctrl.linear)
            begin
                data_next.x = up_data.x;
            end
            else if (ctrl.hyper)
            begin
                data_next.x = neg ? up_data.x - ys : up_data.x + ys;
            end
            else
            begin
                data_next.x = neg ? up_data.x + ys : up_data.x - ys;
            end
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // advance payload on transfer
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: tb/ucq_check_pkg.sv
package ucq_check_pkg;

    import ucq_pkg::*;

    localparam logic signed [DATA_W-1:0] CIRC_ATAN [14] = '{
        16'sd12867, 16'sd7596, 16'sd4013, 16'sd2037, 16'sd1022, 16'sd511, 16'sd255,
        16'sd127, 16'sd63, 16'sd31, 16'sd15, 16'sd7, 16'sd3, 16'sd1
    };

    localparam logic signed [DATA_W-1:0] HYP_ATANH [14] = '{
        16'sd0, 16'sd8999, 16'sd4184, 16'sd2058, 16'sd1025, 16'sd512, 16'sd256,
        16'sd128, 16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2
    };

    class cordic_scoreboard;

        result_t     expected_results [$];
        logic        vectoring;
        logic [1:0]  mode;
        int unsigned errors;

        function new();
            vectoring = 1'b0;
            mode      = MODE_CIRC;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [PDATA_W-1:0] data);
            if (idx == REG_DIRECTION)
            begin
                vectoring = data[0];
            end
            else
            begin
                mode = data[1:0];
            end
        endfunction

        function logic [PDATA_W-1:0] reg_value(logic idx);
            logic [PDATA_W-1:0] v;
            v = '0;
            if (idx == REG_DIRECTION)
            begin
                v[0] = vectoring;
            end
            else
            begin
                v[1:0] = mode;
            end
            return v;
        endfunction

        function result_t rotate_triple(operand_t op);
            logic signed [DATA_W-1:0] x, y, z, xs, ys, t, nx, ny, nz;
            logic [SHIFT_W-1:0]       s;
            logic                     hyper, lin, neg;
            int                       steps;
            result_t                  r;
            hyper = (mode == MODE_HYP);
            lin   = (mode == MODE_LIN);
            x     = op.x_in;
            y     = op.y_in;
            z     = op.z_in;
            steps = hyper ? STEP_COUNT + 1 : STEP_COUNT;
            for (int k = 0; k < steps; k++)
            begin
                neg = vectoring ? !y[DATA_W-1] : z[DATA_W-1];
                if (hyper)
                begin
                    s = (k < 4) ? 4'(k + 1) : ((k < 14) ? 4'(k) : 4'd13);
                    t = HYP_ATANH[s];
                end
                else
                begin
                    s = 4'(k);
                    t = lin ? (ONE_Q14 >>> s) : CIRC_ATAN[k];
                end
                xs = x >>> s;
                if (hyper)
                begin
                    ys = -(y >>> s);
                end
                else if (lin)
                begin
                    ys = '0;
                end
                else
                begin
                    ys = y >>> s;
                end
                if (!neg)
                begin
                    nx = x - ys;
                    ny = y + xs;
                    nz = z - t;
                end
                else
                begin
                    nx = x + ys;
                    ny = y - xs;
                    nz = z + t;
                end
                x = nx;
                y = ny;
                z = nz;
            end
            r.x_out = x;
            r.y_out = y;
            r.z_out = z;
            return r;
        endfunction

        function void note_operand(operand_t op);
            expected_results.push_back(rotate_triple(op));
        endfunction

        function void check_result(result_t got, realtime stamp);
            result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                         stamp, got.x_out, got.y_out, got.z_out);
                return;
            end
            want = expected_results.pop_front();
            if (got.x_out !== want.x_out)
            begin
                errors++;
                $display("%0t: x_out expected %0d actual %0d", stamp, want.x_out, got.x_out);
            end
            if (got.y_out !== want.y_out)
            begin
                errors++;
                $display("%0t: y_out expected %0d actual %0d", stamp, want.y_out, got.y_out);
            end
            if (got.z_out !== want.z_out)
            begin
                errors++;
                $display("%0t: z_out expected %0d actual %0d", stamp, want.z_out, got.z_out);
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

    endclass

endpackage

FILE: tb/unified_cordic_q2_14_tb.sv
module unified_cordic_q2_14_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ucq_pkg::*;
    import ucq_check_pkg::*;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DIRECTED_PER  = 3;
    localparam int RANDOM_FIRST  = 50;
    localparam int RANDOM_SECOND = 100;

    localparam logic signed [DATA_W-1:0] EDGE_VALS [6] = '{
        16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh4000, 16'shC000
    };

    logic               clk;
    logic               rst_n;
    logic               operand_valid;
    logic               operand_ready;
    operand_t           operand;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cordic_scoreboard sb;
    logic             src_idle;
    logic             snk_idle;
    int unsigned      cycle_count;

    unified_cordic_q2_14 uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_ready (operand_ready),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("unified_cordic_q2_14 verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return DATA_W'($urandom);
        end
        else if (r < 9)
        begin
            return DATA_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        return EDGE_VALS[$urandom_range(0, 5)];
    endfunction

    function automatic operand_t rand_operand();
        operand_t op;
        op.x_in = rand_field();
        op.y_in = rand_field();
        op.z_in = rand_field();
        return op;
    endfunction

    function automatic operand_t edge_operand(int idx);
        operand_t op;
        op.x_in = EDGE_VALS[idx % 6];
        op.y_in = EDGE_VALS[(idx + 2 + idx / 6) % 6];
        op.z_in = EDGE_VALS[(idx * 5 + 1) % 6];
        return op;
    endfunction

    // Called and returns at a falling edge
    task automatic apb_write(logic idx, logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.write_reg(idx, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_readback(logic idx);
        logic [PDATA_W-1:0] want;
        want    = sb.reg_value(idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== want)
        begin
            sb.errors++;
            $display("%0t: register %0d read expected %0h actual %0h",
                     $realtime, idx, want, prdata);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic load_setting(int setting);
        logic [PDATA_W-1:0] data;
        data    = $urandom;
        data[0] = setting[0];
        apb_write(REG_DIRECTION, data);
        apb_readback(REG_DIRECTION);
        data      = $urandom;
        data[1:0] = setting[2:1];
        apb_write(REG_MODE, data);
        apb_readback(REG_MODE);
    endtask

    task automatic send_operand(operand_t op);
        int gap;
        gap = src_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            operand_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operand       = op;
        operand_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!operand_ready);
        sb.note_operand(op);
        @(negedge clk);
    endtask

    task automatic drain();
        operand_valid = 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(int directed_base, int directed_n, int random_n);
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < directed_n; i++)
        begin
            send_operand(edge_operand(directed_base + i));
        end
        for (int i = 0; i < random_n; i++)
        begin
            send_operand(rand_operand());
        end
        drain();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                sb.check_result(result, $realtime);
            end
        end
    end

    initial
    begin
        int stall;
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = snk_idle ? gap_len() : 0;
            repeat (stall)
            begin
                @(negedge clk);
                result_ready = 1'b0;
            end
            hold = $urandom_range(1, 8);
            repeat (hold)
            begin
                @(negedge clk);
                result_ready = 1'b1;
            end
        end
    end

    initial
    begin
        int order [8];
        sb            = new();
        cycle_count   = 0;
        src_idle      = 1'b0;
        snk_idle      = 1'b0;
        rst_n         = 1'b0;
        operand_valid = 1'b0;
        operand       = '0;
        result_ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        order         = '{7, 2, 5, 0, 4, 3, 6, 1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // setting 0 runs on reset values
        for (int s = 0; s < 8; s++)
        begin
            if (s != 0)
            begin
                load_setting(s);
            end
            run_phase(s * DIRECTED_PER, DIRECTED_PER, RANDOM_FIRST);
        end
        for (int i = 0; i < 8; i++)
        begin
            load_setting(order[i]);
            run_phase(0, 0, RANDOM_SECOND);
        end

        if (sb.errors == 0)
        begin
            $display("unified_cordic_q2_14 verification clean");
        end
        else
        begin
            $display("unified_cordic_q2_14 verification failed");
        end
        $finish;
    end

endmodule
